[hdl/pdis_pkg.sv]
// Shared types and constants for the per-day interval scheduler.
// No dependencies; every file but pdis_fifo imports this package.
`timescale 1ns / 1ps
`default_nettype none
package pdis_pkg;

   localparam int FIELD_W = 16;

   // Classified interval passed from the front end to the back end
   typedef struct packed {
      logic [FIELD_W-1:0] day;
      logic [FIELD_W-1:0] start_time;
      logic [FIELD_W-1:0] end_time;
      logic               last;
      logic               keep;   // 1: store it, 0: store full, drop it
   } pdis_item_type;

   localparam int ITEM_W = $bits(pdis_item_type);

endpackage
`default_nettype wire

[hdl/pdis_fifo.sv]
// Two-entry queue between the front end and the back end.
// Depends on nothing; width set by parameter.
`timescale 1ns / 1ps
`default_nettype none
module pdis_fifo #(
   parameter int W = 8
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          in_valid,
   output logic         in_ready,
   input  wire  [W-1:0] in_data,
   output logic         out_valid,
   input  wire          out_ready,
   output logic [W-1:0] out_data
);
   logic [W-1:0] slot_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;
   logic         push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = slot_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= in_data;
   end
endmodule
`default_nettype wire

[hdl/pdis_front.sv]
// Front end: accepts intervals and marks each one kept or dropped by capacity.
// Depends on pdis_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pdis_front
   import pdis_pkg::*;
#(
   parameter int MAX_INTERVALS = 256
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  wire  [FIELD_W-1:0]  day,
   input  wire  [FIELD_W-1:0]  start_time,
   input  wire  [FIELD_W-1:0]  end_time,
   input  wire                 last,
   output logic                out_valid,
   input  wire                 out_ready,
   output pdis_item_type       out_item
);
   localparam int CW = $clog2(MAX_INTERVALS + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          keep, take;

   assign keep      = (cnt_ff < CW'(MAX_INTERVALS));
   assign in_ready  = out_ready;
   assign out_valid = in_valid;
   assign take      = in_valid && out_ready;

   // Classify the item
   always_comb begin
      out_item.day        = day;
      out_item.start_time = start_time;
      out_item.end_time   = end_time;
      out_item.last       = last;
      out_item.keep       = keep;
   end

   // Count items of the current set
   always_comb begin
      cnt_in = cnt_ff;
      if (take) begin
         if (last)      cnt_in = '0;
         else if (keep) cnt_in = cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end
endmodule
`default_nettype wire

[hdl/pdis_back.sv]
// Back end: interval store, greedy selection passes and the result register.
// Depends on pdis_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pdis_back
   import pdis_pkg::*;
#(
   parameter int MAX_INTERVALS = 256,
   parameter int TIME_BITS     = 16
) (
   input  wire           clock,
   input  wire           reset,
   input  wire           in_valid,
   output logic          in_ready,
   input  pdis_item_type in_item,
   output logic          rsp_valid,
   input  wire           rsp_ready,
   output logic [8:0]    chosen_count,
   output logic          overflow
);
   localparam int CW  = $clog2(MAX_INTERVALS + 1);
   localparam int AW  = $clog2(MAX_INTERVALS);
   localparam int TCW = (CW > 9) ? CW : 9;
   localparam int EW  = FIELD_W + 2 * TIME_BITS;
   localparam int KW  = EW + AW;

   typedef enum logic [1:0] {LOAD, SCAN, DONE} state_type;

   // Entry layout: day, end, start (sort key order)
   logic [EW-1:0] store [MAX_INTERVALS];

   state_type           state_ff;
   logic [CW-1:0]       n_ff, addr_ff;
   logic [TCW-1:0]      taken_ff;
   logic                ovf_ff, rsp_valid_ff;
   logic [EW-1:0]       rd_data_ff;
   logic [AW-1:0]       rd_idx_ff;
   logic                rd_v_ff, pass_end_ff;
   logic                have_ff, best_v_ff;
   logic [KW-1:0]       last_key_ff, best_key_ff;
   logic [FIELD_W-1:0]  cur_day_ff;
   logic [TIME_BITS-1:0] run_end_ff;

   logic [FIELD_W+TIME_BITS-1:0] st_ext, en_ext;
   logic [EW-1:0]        wr_entry;
   logic [KW-1:0]        rd_key;
   logic [FIELD_W-1:0]   rd_day;
   logic [TIME_BITS-1:0] rd_st;
   logic                 elig, pop, issue;

   assign st_ext   = {{TIME_BITS{1'b0}}, in_item.start_time};
   assign en_ext   = {{TIME_BITS{1'b0}}, in_item.end_time};
   assign wr_entry = {in_item.day, en_ext[TIME_BITS-1:0], st_ext[TIME_BITS-1:0]};

   assign in_ready     = (state_ff == LOAD);
   assign pop          = in_valid && in_ready;
   assign issue        = (state_ff == SCAN) && (addr_ff < n_ff);
   assign rsp_valid    = rsp_valid_ff;
   assign chosen_count = taken_ff[8:0];
   assign overflow     = ovf_ff;

   // Candidate test: after the last pick in key order, and startable
   assign rd_key = {rd_data_ff, rd_idx_ff};
   assign rd_day = rd_data_ff[EW-1 -: FIELD_W];
   assign rd_st  = rd_data_ff[TIME_BITS-1:0];
   assign elig   = (!have_ff || (rd_key > last_key_ff)) &&
                   (!have_ff || (rd_day != cur_day_ff) || (rd_st >= run_end_ff));

   // Store write and registered read
   always_ff @(posedge clock) begin
      if (pop && in_item.keep) store[n_ff[AW-1:0]] <= wr_entry;
      rd_data_ff <= store[addr_ff[AW-1:0]];
      rd_idx_ff  <= addr_ff[AW-1:0];
   end

   // Load, scan passes and result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LOAD;
         n_ff         <= '0;
         addr_ff      <= '0;
         taken_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_v_ff      <= 1'b0;
         pass_end_ff  <= 1'b0;
         have_ff      <= 1'b0;
         best_v_ff    <= 1'b0;
         last_key_ff  <= '0;
         best_key_ff  <= '0;
         cur_day_ff   <= '0;
         run_end_ff   <= '0;
      end else begin
         rd_v_ff     <= issue;
         pass_end_ff <= rd_v_ff && (CW'(rd_idx_ff) == n_ff - CW'(1));
         unique case (state_ff)
            LOAD: begin
               if (pop) begin
                  if (in_item.keep) n_ff <= n_ff + CW'(1);
                  else              ovf_ff <= 1'b1;
                  if (in_item.last) begin
                     state_ff  <= SCAN;
                     addr_ff   <= '0;
                     have_ff   <= 1'b0;
                     best_v_ff <= 1'b0;
                  end
               end
            end
            SCAN: begin
               if (issue) addr_ff <= addr_ff + CW'(1);
               // Keep the smallest eligible key of this pass
               if (rd_v_ff && elig && (!best_v_ff || rd_key < best_key_ff)) begin
                  best_v_ff   <= 1'b1;
                  best_key_ff <= rd_key;
               end
               // Commit the pick and start another pass, or finish
               if (pass_end_ff) begin
                  if (best_v_ff) begin
                     taken_ff    <= taken_ff + TCW'(1);
                     have_ff     <= 1'b1;
                     last_key_ff <= best_key_ff;
                     cur_day_ff  <= best_key_ff[KW-1 -: FIELD_W];
                     run_end_ff  <= best_key_ff[AW+2*TIME_BITS-1 -: TIME_BITS];
                     best_v_ff   <= 1'b0;
                     addr_ff     <= '0;
                  end else begin
                     state_ff     <= DONE;
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            DONE: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= LOAD;
                  n_ff         <= '0;
                  taken_ff     <= '0;
                  ovf_ff       <= 1'b0;
               end
            end
            default: state_ff <= LOAD;
         endcase
      end
   end
endmodule
`default_nettype wire

[hdl/per_day_interval_scheduler.sv]
// Top level of the per-day interval scheduler.
// Depends on pdis_pkg, pdis_front, pdis_fifo and pdis_back.
//
// Usage: intervals arrive on the req_ stream, one item per cycle while
// loading, req_tlast marking the final interval of a set. Items beyond
// MAX_INTERVALS are dropped and flag overflow. After the last item the back
// end runs greedy selection passes over the interval store: each pass reads
// every stored entry once through the store's single read port and picks the
// smallest (day, end, start) interval that can still be taken, so the scan
// makes (picks + 1) passes over the N stored intervals. One result
// item then appears on rsp_ with the chosen count and the overflow flag.
// Loading runs at one item per cycle; during the scan the two-entry queue
// absorbs up to two items of the next set, then req_tready drops.
// Reset (synchronous, active high) empties the queue and set state; the
// store needs no clearing. A stalled rsp_tready holds the result and the
// back end until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module per_day_interval_scheduler
   import pdis_pkg::*;
#(
   parameter int MAX_INTERVALS = 256,
   parameter int TIME_BITS     = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,   // day[15:0], start_time[31:16], end_time[47:32]
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata    // chosen_count[8:0], overflow[9], zero[15:10]
);
   logic          f_valid, f_ready, b_valid, b_ready;
   pdis_item_type f_item, b_item;
   logic [8:0]    chosen_count;
   logic          overflow;

   pdis_front #(.MAX_INTERVALS(MAX_INTERVALS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .day        (req_tdata[15:0]),
      .start_time (req_tdata[31:16]),
      .end_time   (req_tdata[47:32]),
      .last       (req_tlast),
      .out_valid  (f_valid),
      .out_ready  (f_ready),
      .out_item   (f_item)
   );

   pdis_fifo #(.W(ITEM_W)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_item),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (b_item)
   );

   pdis_back #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .TIME_BITS     (TIME_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (b_valid),
      .in_ready     (b_ready),
      .in_item      (b_item),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .chosen_count (chosen_count),
      .overflow     (overflow)
   );

   assign rsp_tdata = {6'd0, overflow, chosen_count};
endmodule
`default_nettype wire

[verif/pdis_checker.sv]
// Checker for the per-day interval scheduler: watches both streams, predicts the result.
// Depends on pdis_pkg only; the testbench top instantiates it beside the block.
`timescale 1ns / 1ps
module pdis_checker
   import pdis_pkg::*;
#(
   parameter int MAX_INTERVALS = 256
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [47:0] req_tdata,   // day[15:0], start_time[31:16], end_time[47:32]
   input  wire         req_tlast,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [15:0] rsp_tdata,   // chosen_count[8:0], overflow[9], zero[15:10]
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [15:0] day;
      logic [15:0] st;
      logic [15:0] en;
   } interval_type;

   typedef struct packed {
      logic [8:0] chosen;
      logic       ovf;
   } sched_result_type;

   interval_type     set_q[$];
   logic             set_ovf;
   sched_result_type result_q[$];

   // Sort by day, end, start and pick greedily within each day
   function automatic sched_result_type schedule_set(input interval_type ivs[$],
                                                     input logic ovf);
      interval_type     arr[$];
      interval_type     cur;
      int               j;
      logic [15:0]      day_now;
      logic             day_open;
      logic [15:0]      run_end;
      int               taken;
      sched_result_type res;
      arr = ivs;
      for (int i = 1; i < arr.size(); i++) begin
         cur = arr[i];
         j = i;
         while (j > 0 && ((cur.day != arr[j-1].day) ? (cur.day < arr[j-1].day) :
                          (cur.en != arr[j-1].en) ? (cur.en < arr[j-1].en) :
                          (cur.st < arr[j-1].st))) begin
            arr[j] = arr[j-1];
            j--;
         end
         arr[j] = cur;
      end
      day_now = '0;
      day_open = 1'b0;
      run_end = '0;
      taken = 0;
      foreach (arr[i]) begin
         if (!day_open || arr[i].day > day_now) begin
            day_now = arr[i].day;
            day_open = 1'b1;
            run_end = '0;
         end
         if (arr[i].day == day_now && run_end <= arr[i].st) begin
            taken++;
            run_end = arr[i].en;
         end
      end
      res.chosen = taken[8:0];
      res.ovf = ovf;
      return res;
   endfunction

   always @(posedge clock) begin
      sched_result_type exp_r;
      interval_type     iv;
      logic             ovf_now;
      if (reset) begin
         set_q.delete();
         set_ovf <= 1'b0;
         fail_count <= 0;
      end else begin
         // collect the set; drop items on a full store and close the set on the last item
         if (req_tvalid && req_tready) begin
            ovf_now = set_ovf;
            iv = {req_tdata[15:0], req_tdata[31:16], req_tdata[47:32]};
            if (set_q.size() < MAX_INTERVALS)
               set_q.insert(set_q.size(), iv);
            else
               ovf_now = 1'b1;
            if (req_tlast) begin
               result_q.insert(result_q.size(), schedule_set(set_q, ovf_now));
               set_q.delete();
               set_ovf <= 1'b0;
            end else begin
               set_ovf <= ovf_now;
            end
         end
         // compare each result item with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (result_q.size() == 0) begin
               $display("%0t: unexpected result item %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = result_q.pop_front();
               if (rsp_tdata[8:0] !== exp_r.chosen) begin
                  $display("%0t: chosen_count expected %0d actual %0d",
                           $time, exp_r.chosen, rsp_tdata[8:0]);
                  fail_count <= fail_count + 1;
               end else if (rsp_tdata[9] !== exp_r.ovf) begin
                  $display("%0t: overflow expected %0b actual %0b",
                           $time, exp_r.ovf, rsp_tdata[9]);
                  fail_count <= fail_count + 1;
               end else if (rsp_tdata[15:10] !== 6'd0) begin
                  $display("%0t: pad bits expected 0 actual %h", $time, rsp_tdata[15:10]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= result_q.size();
   end

endmodule

[verif/testbench.sv]
// Testbench top for the per-day interval scheduler: drives interval sets and gives the verdict.
// Depends on pdis_pkg, per_day_interval_scheduler and pdis_checker.
`timescale 1ns / 1ps
module testbench;
   import pdis_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [47:0] req_tdata = '0;   // day[15:0], start_time[31:16], end_time[47:32]
   logic        req_tlast = 1'b0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [15:0] rsp_tdata;        // chosen_count[8:0], overflow[9], zero[15:10]
   int          fail_count;
   int          pending;
   int          stall_left = 0;
   logic        stall_on = 1'b0;

   per_day_interval_scheduler u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   pdis_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Receiver: alternate ready stretches with stall stretches of random length
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_on <= ($urandom_range(0, 2) == 0);
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(0, 4);
         rsp_tready <= !(($urandom_range(0, 2) == 0));
      end
      if (stall_left > 0)
         rsp_tready <= !stall_on;
   end

   // Present one interval and hold it until accepted, then idle for a random gap, possibly none
   task automatic send_interval(input logic [15:0] day, input logic [15:0] st,
                                input logic [15:0] en, input logic last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {en, st, day};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] pick_field(input int mode);
      case (mode)
         0: return 16'($urandom_range(0, 3));
         1: return 16'($urandom_range(0, 40));
         default: return 16'($urandom_range(0, 16'hffff));
      endcase
   endfunction

   // One random set; mostly clustered values so the greedy choice matters
   task automatic send_random_set(input int count);
      int          mode;
      logic [15:0] st;
      logic [15:0] en;
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(0, 9);
         st = pick_field(mode < 7 ? 1 : 2);
         en = (mode < 6) ? 16'(st + 16'($urandom_range(0, 12)))
                         : pick_field(mode < 8 ? 1 : 2);
         send_interval(pick_field(mode < 5 ? 0 : (mode < 8 ? 1 : 2)), st, en,
                       i == count - 1);
      end
   endtask

   initial begin
      int sent;
      int count;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single item on day zero with zero length
      send_interval(16'd0, 16'd0, 16'd0, 1'b1);
      // extremes of every field
      send_interval(16'hffff, 16'hffff, 16'hffff, 1'b1);
      send_interval(16'hffff, 16'd0, 16'hffff, 1'b0);
      send_interval(16'h0000, 16'hffff, 16'h0000, 1'b1);
      // overlaps, back-to-back, unsorted input and day changes
      send_interval(16'd2, 16'd5, 16'd9, 1'b0);
      send_interval(16'd2, 16'd1, 16'd5, 1'b0);
      send_interval(16'd2, 16'd4, 16'd6, 1'b0);
      send_interval(16'd0, 16'd3, 16'd8, 1'b0);
      send_interval(16'd1, 16'd0, 16'd2, 1'b0);
      send_interval(16'd1, 16'd2, 16'd4, 1'b0);
      send_interval(16'd2, 16'd9, 16'd9, 1'b1);
      // start after end, and duplicates
      send_interval(16'd5, 16'd10, 16'd3, 1'b0);
      send_interval(16'd5, 16'd3, 16'd7, 1'b0);
      send_interval(16'd5, 16'd3, 16'd7, 1'b0);
      send_interval(16'd5, 16'd8, 16'd8, 1'b1);
      sent = 15;

      // random sets, mostly small; a few fill the store or overflow it
      while (sent < 1300) begin
         case ($urandom_range(0, 39))
            0: count = $urandom_range(250, 262);
            1, 2: count = $urandom_range(20, 60);
            default: count = $urandom_range(1, 12);
         endcase
         send_random_set(count);
         sent += count;
      end
      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;

      // let the checker record the final set before waiting on it
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
